FILE: design/fir_filter_64_tap_macros.svh
// Assertion macros used by the FIR filter RTL.
`ifndef FIR_FILTER_64_TAP_MACROS_SVH
`define FIR_FILTER_64_TAP_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define FIR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fir_filter_64_tap: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fir_filter_64_tap: next-cycle check failed");

`endif

FILE: design/fir64_pkg.sv
// Shared constants, coefficient table and control types of the 64-tap FIR filter.
package fir64_pkg;

   localparam int TAPS     = 64;
   localparam int NCOEF    = 64;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = $clog2(NCOEF);
   localparam int IDX_W    = $clog2(TAPS);
   localparam int FILL_W   = $clog2(TAPS + 1);
   localparam int WIDE_W   = IDX_W + COEF_W + 1;
   localparam int PROD_W   = 32;
   localparam int ACC_W    = 40;
   localparam int FRAC_W   = 15;

   // Q1.15 low-pass coefficients, tap 0 applies to the newest sample
   localparam logic signed [SAMPLE_W-1:0] COEF [NCOEF] = '{
         -16'sd6,    -16'sd37,   -16'sd24,    16'sd38,    16'sd70,     16'sd3,   -16'sd99,
        -16'sd87,     16'sd65,   16'sd173,    16'sd53,  -16'sd188,  -16'sd222,    16'sd67,
        16'sd344,    16'sd191,  -16'sd292,  -16'sd481,    -16'sd9,   16'sd615,   16'sd508,
       -16'sd393,   -16'sd990,  -16'sd288,  16'sd1113,  16'sd1345,  -16'sd465, -16'sd2512,
      -16'sd1600,   16'sd3424,  16'sd9739, 16'sd12616,  16'sd9739,  16'sd3424, -16'sd1600,
      -16'sd2512,   -16'sd465,  16'sd1345,  16'sd1113,  -16'sd288,  -16'sd990,  -16'sd393,
        16'sd508,    16'sd615,    -16'sd9,  -16'sd481,  -16'sd292,   16'sd191,   16'sd344,
         16'sd67,   -16'sd222,  -16'sd188,    16'sd53,   16'sd173,    16'sd65,   -16'sd87,
        -16'sd99,      16'sd3,    16'sd70,    16'sd38,   -16'sd24,   -16'sd37,    -16'sd6,
          16'sd0
   };

   // Control from the sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic en;
   } mac_ctl_type;

   // Coefficient of a tap; taps past the table have weight zero
   function automatic logic signed [SAMPLE_W-1:0] coef_at(input logic [IDX_W-1:0] idx);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(idx);
      if (wide < WIDE_W'(NCOEF)) begin
         return COEF[wide[COEF_W-1:0]];
      end
      return '0;
   endfunction

endpackage

FILE: design/fir64_cell.sv
// One cell of the sample ring: holds a sample and takes its neighbor's value on enable.
module fir64_cell
   import fir64_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic signed [SAMPLE_W-1:0] d_in,
   output logic signed [SAMPLE_W-1:0] q
);

   logic signed [SAMPLE_W-1:0] q_ff;
   logic signed [SAMPLE_W-1:0] q_in;

   // take the neighbor's sample when the ring moves
   always_comb begin
      q_in = en ? d_in : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;

endmodule

FILE: design/fir64_mac.sv
// Multiply-accumulate unit at the ring tail, with rounding and saturation to Q1.15.
module fir64_mac
   import fir64_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] tail,
   input  logic [IDX_W-1:0]           idx,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int SHR_W = ACC_W + 1 - FRAC_W;
   localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'(32767);
   localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(32768);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W:0]    rnd;
   logic signed [SHR_W-1:0]  shr;

   // product stage, then accumulate stage
   always_comb begin
      prod_in = tail * coef_at(idx);
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.en;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // round half up, drop fraction bits, clamp to 16 bits
   always_comb begin
      rnd = {acc_ff[ACC_W-1], acc_ff} + (ACC_W+1)'(16384);
      shr = rnd[ACC_W:FRAC_W];
      if (shr > SAT_MAX) begin
         result = SAT_MAX[SAMPLE_W-1:0];
      end else if (shr < SAT_MIN) begin
         result = SAT_MIN[SAMPLE_W-1:0];
      end else begin
         result = shr[SAMPLE_W-1:0];
      end
   end

endmodule

FILE: design/fir_filter_64_tap.sv
// Samples enter a ring of TAPS cells. A sample that arrives before the block has filled
// the window is stored and produces no output. Once TAPS samples of the block are held,
// an arriving sample makes the ring rotate once around past a single multiply-accumulate
// unit at its tail, then the product register drains, and then the sum is rounded,
// saturated and loaded into the result register while the sample is shifted in, after
// any wait for the result register to be taken. No new sample is accepted until this
// sequence is through. A sample flagged with tlast is stored, may still produce an
// output from the window before it, and then restarts the fill count. The result
// register lets the next sample be accepted while a result is still waiting.
module fir_filter_64_tap
   import fir64_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] sample
   input  logic        req_tlast,  // last_in_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [15:0] filtered
);

   `include "fir_filter_64_tap_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type                  state_ff;
   state_type                  state_in;
   logic [IDX_W-1:0]           idx_ff;
   logic [IDX_W-1:0]           idx_in;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       last_ff;
   logic                       last_in;
   logic                       rsp_tvalid_ff;
   logic                       rsp_tvalid_in;
   logic [SAMPLE_W-1:0]        rsp_tdata_ff;
   logic [SAMPLE_W-1:0]        rsp_tdata_in;

   logic                       req_accept;
   logic                       fill_full;
   logic                       out_free;
   logic                       shift_en;
   logic                       rotate_en;
   logic                       store_last;
   logic signed [SAMPLE_W-1:0] shift_src;
   logic signed [SAMPLE_W-1:0] mac_result;
   mac_ctl_type                mac_ctl;
   logic signed [SAMPLE_W-1:0] ring_q [TAPS];
   logic signed [SAMPLE_W-1:0] ring_d [TAPS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign fill_full  = (fill_ff == FILL_W'(TAPS));
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // ring moves: shift a new sample in, or rotate during the sum
   assign rotate_en  = (state_ff == ST_RUN);
   assign shift_en   = (req_accept && !fill_full) || ((state_ff == ST_FINISH) && out_free);
   assign shift_src  = (state_ff == ST_IDLE) ? req_tdata : sample_ff;
   assign store_last = (state_ff == ST_IDLE) ? req_tlast : last_ff;

   generate
      for (genvar g = 0; g < TAPS; g++) begin : g_ring
         if (g == 0) begin : g_head
            assign ring_d[g] = shift_en ? shift_src : ring_q[TAPS-1];
         end else begin : g_body
            assign ring_d[g] = ring_q[g-1];
         end
         fir64_cell u_cell (
            .clock (clock),
            .reset (reset),
            .en    (shift_en || rotate_en),
            .d_in  (ring_d[g]),
            .q     (ring_q[g])
         );
      end
   endgenerate

   // accumulate over the ring tail while it rotates
   assign mac_ctl.clear = req_accept && fill_full;
   assign mac_ctl.en    = rotate_en;

   fir64_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .tail   (ring_q[TAPS-1]),
      .idx    (idx_ff),
      .result (mac_result)
   );

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      sample_in     = sample_ff;
      last_in       = last_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_tdata;
               last_in   = req_tlast;
               if (fill_full) begin
                  state_in = ST_RUN;
                  idx_in   = IDX_W'(TAPS - 1);
               end
            end
         end
         ST_RUN: begin
            idx_in = idx_ff - IDX_W'(1);
            if (idx_ff == '0) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = mac_result;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // count stored samples of the block, restart after the last one
      if (shift_en) begin
         if (store_last) begin
            fill_in = '0;
         end else if (!fill_full) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      idx_ff       <= idx_in;
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a full window starts the rotation
   `FIR_ASSERT_NEXT(a_full_starts_run, req_accept && fill_full, state_ff == ST_RUN)
   // the rotation ends after the tap at index zero
   `FIR_ASSERT_NEXT(a_run_ends, (state_ff == ST_RUN) && (idx_ff == '0), state_ff == ST_FLUSH)
   // a finished sum with a free result register is presented next cycle
   `FIR_ASSERT_NEXT(a_emit, (state_ff == ST_FINISH) && out_free, rsp_tvalid && !req_tready == 1'b0)
   // the fill count never passes the window length
   `FIR_ASSERT_SAME(a_fill_bound, shift_en || rotate_en, fill_ff <= FILL_W'(TAPS))

endmodule
